// ----- hw/rtl/otsu_pkg.sv -----
// Shared types and constants for the Otsu threshold search block.
// Used by otsu_hist_mem, otsu_score and otsu_threshold_search.
package otsu_pkg;

   localparam int BINS    = 65536;
   localparam int STEP    = 256;
   localparam int HIST_AW = $clog2(BINS);

   localparam int BIN_W = 16;   // bin index / pixel value
   localparam int CNT_W = 32;   // bin count, total count
   localparam int SUM_W = 48;   // value-weighted sums
   localparam int PRD_W = 80;   // sl*N and S*wl
   localparam int SQ_W  = 160;  // D^2
   localparam int DEN_W = 64;   // wl*wr
   localparam int ACC_W = 224;  // D^2 * den
   localparam int MB_W  = 80;   // widest serial multiplier operand
   localparam int MC_W  = 7;    // serial multiply bit counter
   localparam int T_W   = 17;   // candidate threshold, may sit one past the top bin

   typedef enum logic [1:0] {
      FUNC_CLEAR    = 2'd0,
      FUNC_ADD      = 2'd1,
      FUNC_SEARCH   = 2'd2,
      FUNC_CLASSIFY = 2'd3
   } func_type;

   localparam logic [1:0] STATUS_ACK   = 2'd0;
   localparam logic [1:0] STATUS_FOUND = 2'd1;
   localparam logic [1:0] STATUS_NONE  = 2'd2;

   localparam logic CSR_COARSE_OFFSET = 1'b0;
   localparam logic CSR_BINARY_OUTPUT = 1'b1;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] wl;
      logic [SUM_W-1:0] sl;
   } score_req_type;

   typedef struct packed {
      logic             done;
      logic             better;
      logic [SQ_W-1:0]  sq;
      logic [DEN_W-1:0] den;
   } score_res_type;

endpackage

// ----- hw/rtl/otsu_hist_mem.sv -----
// Histogram store: BINS x 32-bit single-port-write, registered-read memory.
// Depends on otsu_pkg.
module otsu_hist_mem (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [otsu_pkg::HIST_AW-1:0] wr_addr,
   input  logic [otsu_pkg::CNT_W-1:0]  wr_data,
   input  logic [otsu_pkg::HIST_AW-1:0] rd_addr,
   output logic [otsu_pkg::CNT_W-1:0]  rd_data
);

   logic [otsu_pkg::CNT_W-1:0] mem [otsu_pkg::BINS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- hw/rtl/otsu_score.sv -----
// Exact score comparison for one candidate threshold, using one shift-add
// multiplier over several phases. Depends on otsu_pkg.
module otsu_score (
   input  logic                          clock,
   input  logic                          reset,
   input  otsu_pkg::score_req_type       req,
   input  logic [otsu_pkg::CNT_W-1:0]    total_count,
   input  logic [otsu_pkg::SUM_W-1:0]    total_sum,
   input  logic [otsu_pkg::SQ_W-1:0]     best_sq,
   input  logic [otsu_pkg::DEN_W-1:0]    best_den,
   output otsu_pkg::score_res_type       res
);

   typedef enum logic [6:0] {
      SC_IDLE = 7'b0000001,
      SC_P1   = 7'b0000010,
      SC_P2   = 7'b0000100,
      SC_SQ   = 7'b0001000,
      SC_LHS  = 7'b0010000,
      SC_RHS  = 7'b0100000,
      SC_DONE = 7'b1000000
   } phase_type;

   phase_type                     phase_ff, phase_in;
   logic [otsu_pkg::ACC_W-1:0]    a_ff, a_in;
   logic [otsu_pkg::MB_W-1:0]     b_ff, b_in;
   logic [otsu_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic [otsu_pkg::MC_W-1:0]     cnt_ff, cnt_in;
   logic [otsu_pkg::CNT_W-1:0]    wl_ff, wl_in;
   logic [otsu_pkg::PRD_W-1:0]    p1_ff, p1_in;
   logic [otsu_pkg::SQ_W-1:0]     sq_ff, sq_in;
   logic [otsu_pkg::ACC_W-1:0]    lhs_ff, lhs_in;
   logic [otsu_pkg::DEN_W-1:0]    den_ff, den_in;
   logic                          better_ff, better_in;

   always_comb begin
      logic [otsu_pkg::ACC_W-1:0] mac_sum;
      logic [otsu_pkg::PRD_W-1:0] p2;
      logic [otsu_pkg::PRD_W-1:0] diff;
      logic [otsu_pkg::CNT_W-1:0] wr;

      phase_in  = phase_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      wl_in     = wl_ff;
      p1_in     = p1_ff;
      sq_in     = sq_ff;
      lhs_in    = lhs_ff;
      den_in    = den_ff;
      better_in = better_ff;

      mac_sum = acc_ff + (b_ff[0] ? a_ff : '0);
      p2      = acc_ff[otsu_pkg::PRD_W-1:0];
      diff    = (p1_ff >= p2) ? (p1_ff - p2) : (p2 - p1_ff);
      wr      = total_count - req.wl;

      unique case (phase_ff)
         SC_IDLE: begin
            if (req.start) begin
               wl_in    = req.wl;
               den_in   = otsu_pkg::DEN_W'(req.wl) * otsu_pkg::DEN_W'(wr);
               a_in     = otsu_pkg::ACC_W'(req.sl);
               b_in     = otsu_pkg::MB_W'(total_count);
               acc_in   = '0;
               cnt_in   = otsu_pkg::MC_W'(otsu_pkg::CNT_W);
               phase_in = SC_P1;
            end
         end
         SC_P1, SC_P2, SC_SQ, SC_LHS, SC_RHS: begin
            if (cnt_ff != '0) begin
               acc_in = mac_sum;
               a_in   = a_ff << 1;
               b_in   = b_ff >> 1;
               cnt_in = cnt_ff - 1'b1;
            end else begin
               acc_in = '0;
               case (phase_ff)
                  SC_P1: begin
                     p1_in    = acc_ff[otsu_pkg::PRD_W-1:0];
                     a_in     = otsu_pkg::ACC_W'(total_sum);
                     b_in     = otsu_pkg::MB_W'(wl_ff);
                     cnt_in   = otsu_pkg::MC_W'(otsu_pkg::CNT_W);
                     phase_in = SC_P2;
                  end
                  SC_P2: begin
                     // D = |sl*N - S*wl|, then D^2
                     a_in     = otsu_pkg::ACC_W'(diff);
                     b_in     = otsu_pkg::MB_W'(diff);
                     cnt_in   = otsu_pkg::MC_W'(otsu_pkg::PRD_W);
                     phase_in = SC_SQ;
                  end
                  SC_SQ: begin
                     sq_in    = acc_ff[otsu_pkg::SQ_W-1:0];
                     a_in     = otsu_pkg::ACC_W'(acc_ff[otsu_pkg::SQ_W-1:0]);
                     b_in     = otsu_pkg::MB_W'(best_den);
                     cnt_in   = otsu_pkg::MC_W'(otsu_pkg::DEN_W);
                     phase_in = SC_LHS;
                  end
                  SC_LHS: begin
                     lhs_in   = acc_ff;
                     a_in     = otsu_pkg::ACC_W'(best_sq);
                     b_in     = otsu_pkg::MB_W'(den_ff);
                     cnt_in   = otsu_pkg::MC_W'(otsu_pkg::DEN_W);
                     phase_in = SC_RHS;
                  end
                  default: begin
                     // new D^2*best_den against best D^2*den
                     better_in = lhs_ff > acc_ff;
                     phase_in  = SC_DONE;
                  end
               endcase
            end
         end
         SC_DONE: begin
            phase_in = SC_IDLE;
         end
         default: begin
            phase_in = SC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= SC_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      acc_ff    <= acc_in;
      cnt_ff    <= cnt_in;
      wl_ff     <= wl_in;
      p1_ff     <= p1_in;
      sq_ff     <= sq_in;
      lhs_ff    <= lhs_in;
      den_ff    <= den_in;
      better_ff <= better_in;
   end

   assign res.done   = (phase_ff == SC_DONE);
   assign res.better = better_ff;
   assign res.sq     = sq_ff;
   assign res.den    = den_ff;

endmodule

// ----- hw/rtl/otsu_threshold_search.sv -----
// Otsu threshold search: top level with histogram walk sequencer.
// Depends on otsu_pkg, otsu_hist_mem and otsu_score.
// One item at a time; the histogram memory port and the serial scorer set it.
// Reset clears all bins in a sweep during which req_ready stays low.
module otsu_threshold_search (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_bin_value,
   input  logic [31:0] req_bin_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_result_value,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic        csr_write_data
);

   typedef enum logic [7:0] {
      ST_SWEEP    = 8'b00000001,
      ST_IDLE     = 8'b00000010,
      ST_ADD      = 8'b00000100,
      ST_CHECK    = 8'b00001000,
      ST_ACC      = 8'b00010000,
      ST_SCORE    = 8'b00100000,
      ST_PASS_END = 8'b01000000,
      ST_DONE     = 8'b10000000
   } state_type;

   state_type                        state_ff, state_in;
   logic [otsu_pkg::HIST_AW-1:0]     sweep_ff, sweep_in;
   logic                             clear_pend_ff, clear_pend_in;
   logic [otsu_pkg::CNT_W-1:0]       total_count_ff, total_count_in;
   logic [otsu_pkg::SUM_W-1:0]       total_sum_ff, total_sum_in;
   logic [otsu_pkg::BIN_W-1:0]       lo_ff, lo_in;
   logic [otsu_pkg::BIN_W-1:0]       hi_ff, hi_in;
   logic [otsu_pkg::CNT_W-1:0]       add_amt_ff, add_amt_in;
   logic [otsu_pkg::BIN_W-1:0]       add_bin_ff, add_bin_in;
   logic [otsu_pkg::BIN_W-1:0]       best_thr_ff, best_thr_in;
   logic [otsu_pkg::SQ_W-1:0]        best_sq_ff, best_sq_in;
   logic [otsu_pkg::DEN_W-1:0]       best_den_ff, best_den_in;
   logic                             found_ff, found_in;
   logic                             fine_ff, fine_in;
   logic [otsu_pkg::BIN_W-1:0]       pos_ff, pos_in;
   logic [otsu_pkg::T_W-1:0]         t_ff, t_in;
   logic [otsu_pkg::T_W-1:0]         last_ff, last_in;
   logic [otsu_pkg::T_W-1:0]         stride_ff, stride_in;
   logic [otsu_pkg::CNT_W-1:0]       wl_ff, wl_in;
   logic [otsu_pkg::SUM_W-1:0]       sl_ff, sl_in;
   logic [1:0]                       res_status_ff, res_status_in;
   logic [15:0]                      res_value_ff, res_value_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [1:0]                       rsp_status_ff, rsp_status_in;
   logic [15:0]                      rsp_value_ff, rsp_value_in;
   logic                             coarse_off_ff, coarse_off_in;
   logic                             binary_out_ff, binary_out_in;

   logic                             mem_wr_en;
   logic [otsu_pkg::HIST_AW-1:0]     mem_wr_addr;
   logic [otsu_pkg::CNT_W-1:0]       mem_wr_data;
   logic [otsu_pkg::HIST_AW-1:0]     mem_rd_addr;
   logic [otsu_pkg::CNT_W-1:0]       mem_rd_data;

   otsu_pkg::score_req_type          score_req;
   otsu_pkg::score_res_type          score_res;

   logic                             out_free;
   logic                             accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   otsu_hist_mem u_hist (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   otsu_score u_score (
      .clock       (clock),
      .reset       (reset),
      .req         (score_req),
      .total_count (total_count_ff),
      .total_sum   (total_sum_ff),
      .best_sq     (best_sq_ff),
      .best_den    (best_den_ff),
      .res         (score_res)
   );

   always_comb begin
      logic [otsu_pkg::CNT_W-1:0] room;
      logic [otsu_pkg::CNT_W-1:0] add_c;
      logic [otsu_pkg::T_W:0]     lo_p1;
      logic [otsu_pkg::T_W:0]     c_ext;
      logic [otsu_pkg::T_W:0]     f_first;
      logic [otsu_pkg::T_W:0]     f_last;
      logic [otsu_pkg::T_W:0]     hi_ext;

      state_in       = state_ff;
      sweep_in       = sweep_ff;
      clear_pend_in  = clear_pend_ff;
      total_count_in = total_count_ff;
      total_sum_in   = total_sum_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      add_amt_in     = add_amt_ff;
      add_bin_in     = add_bin_ff;
      best_thr_in    = best_thr_ff;
      best_sq_in     = best_sq_ff;
      best_den_in    = best_den_ff;
      found_in       = found_ff;
      fine_in        = fine_ff;
      pos_in         = pos_ff;
      t_in           = t_ff;
      last_in        = last_ff;
      stride_in      = stride_ff;
      wl_in          = wl_ff;
      sl_in          = sl_ff;
      res_status_in  = res_status_ff;
      res_value_in   = res_value_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_value_in   = rsp_value_ff;
      coarse_off_in  = coarse_off_ff;
      binary_out_in  = binary_out_ff;

      mem_wr_en   = 1'b0;
      mem_wr_addr = add_bin_ff[otsu_pkg::HIST_AW-1:0];
      mem_wr_data = mem_rd_data + add_amt_ff;
      mem_rd_addr = pos_ff[otsu_pkg::HIST_AW-1:0];

      score_req.start = 1'b0;
      score_req.wl    = wl_ff;
      score_req.sl    = sl_ff;

      room  = ~total_count_ff;
      add_c = (req_bin_count < room) ? req_bin_count : room;

      // fine pass window: best - STEP to best + STEP - 1, clipped to thresholds that split
      lo_p1   = (otsu_pkg::T_W + 1)'(lo_ff) + 1'b1;
      c_ext   = (otsu_pkg::T_W + 1)'(best_thr_ff);
      hi_ext  = (otsu_pkg::T_W + 1)'(hi_ff);
      f_first = (c_ext >= lo_p1 + (otsu_pkg::T_W + 1)'(otsu_pkg::STEP))
                ? c_ext - (otsu_pkg::T_W + 1)'(otsu_pkg::STEP) : lo_p1;
      f_last  = c_ext + (otsu_pkg::T_W + 1)'(otsu_pkg::STEP - 1);
      if (f_last > hi_ext) begin
         f_last = hi_ext;
      end

      if (csr_write_enable) begin
         unique case (csr_index)
            otsu_pkg::CSR_COARSE_OFFSET: coarse_off_in = csr_write_data;
            otsu_pkg::CSR_BINARY_OUTPUT: binary_out_in = csr_write_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_SWEEP: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = sweep_ff;
            mem_wr_data = '0;
            sweep_in    = sweep_ff + 1'b1;
            if (sweep_ff == otsu_pkg::HIST_AW'(otsu_pkg::BINS - 1)) begin
               clear_pend_in = 1'b0;
               res_status_in = otsu_pkg::STATUS_ACK;
               res_value_in  = '0;
               state_in      = clear_pend_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            mem_rd_addr = req_bin_value[otsu_pkg::HIST_AW-1:0];
            if (accept) begin
               res_status_in = otsu_pkg::STATUS_ACK;
               res_value_in  = '0;
               unique case (otsu_pkg::func_type'(req_func))
                  otsu_pkg::FUNC_CLEAR: begin
                     total_count_in = '0;
                     total_sum_in   = '0;
                     lo_in          = '1;
                     hi_in          = '0;
                     sweep_in       = '0;
                     clear_pend_in  = 1'b1;
                     state_in       = ST_SWEEP;
                  end
                  otsu_pkg::FUNC_ADD: begin
                     add_amt_in = add_c;
                     add_bin_in = req_bin_value;
                     if ((otsu_pkg::T_W'(req_bin_value) < otsu_pkg::T_W'(otsu_pkg::BINS))
                         && (add_c != '0)) begin
                        state_in = ST_ADD;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  otsu_pkg::FUNC_SEARCH: begin
                     best_thr_in = '0;
                     best_sq_in  = '0;
                     best_den_in = otsu_pkg::DEN_W'(1);
                     found_in    = 1'b0;
                     fine_in     = 1'b0;
                     pos_in      = lo_ff;
                     wl_in       = '0;
                     sl_in       = '0;
                     t_in        = otsu_pkg::T_W'(lo_ff) + otsu_pkg::T_W'(coarse_off_ff);
                     last_in     = otsu_pkg::T_W'(hi_ff);
                     stride_in   = otsu_pkg::T_W'(otsu_pkg::STEP);
                     state_in    = ST_CHECK;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = otsu_pkg::STATUS_ACK;
                     if (req_bin_value < best_thr_ff) begin
                        rsp_value_in = '0;
                     end else if (binary_out_ff) begin
                        rsp_value_in = 16'd1;
                     end else begin
                        rsp_value_in = req_bin_value;
                     end
                  end
               endcase
            end
         end
         ST_ADD: begin
            mem_wr_en      = 1'b1;
            total_count_in = total_count_ff + add_amt_ff;
            total_sum_in   = total_sum_ff
                             + otsu_pkg::SUM_W'(add_amt_ff) * otsu_pkg::SUM_W'(add_bin_ff);
            if (add_bin_ff < lo_ff) begin
               lo_in = add_bin_ff;
            end
            if (add_bin_ff > hi_ff) begin
               hi_in = add_bin_ff;
            end
            state_in = ST_DONE;
         end
         ST_CHECK: begin
            if (t_ff > last_ff) begin
               state_in = ST_PASS_END;
            end else if (otsu_pkg::T_W'(pos_ff) == t_ff) begin
               // prefix up to t is complete; skip thresholds with an empty class
               if ((wl_ff != '0) && (wl_ff < total_count_ff)) begin
                  score_req.start = 1'b1;
                  state_in        = ST_SCORE;
               end else begin
                  t_in = t_ff + stride_ff;
               end
            end else begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            wl_in    = wl_ff + mem_rd_data;
            sl_in    = sl_ff + otsu_pkg::SUM_W'(mem_rd_data) * otsu_pkg::SUM_W'(pos_ff);
            pos_in   = pos_ff + 1'b1;
            state_in = ST_CHECK;
         end
         ST_SCORE: begin
            if (score_res.done) begin
               if (score_res.better) begin
                  best_thr_in = t_ff[otsu_pkg::BIN_W-1:0];
                  best_sq_in  = score_res.sq;
                  best_den_in = score_res.den;
                  found_in    = 1'b1;
               end
               t_in     = t_ff + stride_ff;
               state_in = ST_CHECK;
            end
         end
         ST_PASS_END: begin
            if (!fine_ff) begin
               fine_in   = 1'b1;
               pos_in    = lo_ff;
               wl_in     = '0;
               sl_in     = '0;
               t_in      = f_first[otsu_pkg::T_W-1:0];
               last_in   = f_last[otsu_pkg::T_W-1:0];
               stride_in = otsu_pkg::T_W'(1);
               state_in  = ST_CHECK;
            end else begin
               res_status_in = found_ff ? otsu_pkg::STATUS_FOUND : otsu_pkg::STATUS_NONE;
               res_value_in  = found_ff ? best_thr_ff : '0;
               state_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_SWEEP;
         sweep_ff       <= '0;
         clear_pend_ff  <= 1'b0;
         total_count_ff <= '0;
         total_sum_ff   <= '0;
         lo_ff          <= '1;
         hi_ff          <= '0;
         best_thr_ff    <= '0;
         best_sq_ff     <= '0;
         best_den_ff    <= otsu_pkg::DEN_W'(1);
         found_ff       <= 1'b0;
         fine_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         coarse_off_ff  <= 1'b1;
         binary_out_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sweep_ff       <= sweep_in;
         clear_pend_ff  <= clear_pend_in;
         total_count_ff <= total_count_in;
         total_sum_ff   <= total_sum_in;
         lo_ff          <= lo_in;
         hi_ff          <= hi_in;
         best_thr_ff    <= best_thr_in;
         best_sq_ff     <= best_sq_in;
         best_den_ff    <= best_den_in;
         found_ff       <= found_in;
         fine_ff        <= fine_in;
         rsp_valid_ff   <= rsp_valid_in;
         coarse_off_ff  <= coarse_off_in;
         binary_out_ff  <= binary_out_in;
      end
   end

   always_ff @(posedge clock) begin
      add_amt_ff    <= add_amt_in;
      add_bin_ff    <= add_bin_in;
      pos_ff        <= pos_in;
      t_ff          <= t_in;
      last_ff       <= last_in;
      stride_ff     <= stride_in;
      wl_ff         <= wl_in;
      sl_ff         <= sl_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_value = rsp_value_ff;

endmodule
